// File: hw/rtl/fall_stability_classifier_defines.svh
// Assertion macros for the fall stability classifier
`ifndef FALL_STABILITY_CLASSIFIER_DEFINES_SVH
`define FALL_STABILITY_CLASSIFIER_DEFINES_SVH
`ifndef SYNTHESIS
`define FSC_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define FSC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define FSC_ASSERT_IMPL(lbl, ante, cons, msg)
`define FSC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// File: hw/rtl/fsc_pkg.sv
// Shared types and constants of the fall stability classifier
`timescale 1ns / 1ps
package fsc_pkg;

	localparam logic [2:0] REG_FALLEN_COS        = 3'd0;
	localparam logic [2:0] REG_GYRO_MEAN         = 3'd1;
	localparam logic [2:0] REG_GYRO_ALPHA        = 3'd2;
	localparam logic [2:0] REG_GYRO_FALLING      = 3'd3;
	localparam logic [2:0] REG_ACC_MAG_ALPHA     = 3'd4;
	localparam logic [2:0] REG_ACC_MAG_FALLING   = 3'd5;
	localparam logic [2:0] REG_ACC_ANGLE_ALPHA   = 3'd6;
	localparam logic [2:0] REG_ACC_ANGLE_FALLING = 3'd7;

	localparam logic [1:0] ST_FALLEN   = 2'd0;
	localparam logic [1:0] ST_FALLING  = 2'd1;
	localparam logic [1:0] ST_STANDING = 2'd2;
	localparam logic [1:0] ST_STATIC   = 2'd3;

	localparam logic [16:0] ONE_Q16 = 17'd65536;
	localparam logic signed [23:0] HORNER_C3 = -24'sd19639;
	localparam logic signed [23:0] HORNER_C2 = 24'sd77869;
	localparam logic signed [23:0] HORNER_C1 = -24'sd222419;
	localparam logic signed [23:0] HORNER_C0 = 24'sd1647030;

	localparam logic [5:0] ROOT_LAST = 6'd16;
	localparam logic [5:0] DIV_LAST  = 6'd31;

	typedef struct packed {
		logic signed [15:0] fallen_cos;
		logic [16:0]        gyro_mean;
		logic [15:0]        gyro_alpha;
		logic [16:0]        gyro_falling;
		logic [15:0]        acc_mag_alpha;
		logic [15:0]        acc_mag_falling;
		logic [15:0]        acc_angle_alpha;
		logic [14:0]        acc_angle_falling;
	} cfg_t;

	typedef enum logic [3:0] {
		OP_NOP, OP_SQ, OP_ROOT_INIT, OP_ROOT_STEP, OP_NORM, OP_DIV_INIT, OP_DIV_STEP,
		OP_QFIN, OP_HMUL, OP_HADD, OP_TMUL, OP_TILT, OP_SMA, OP_SMB, OP_SAVG, OP_RESULT
	} op_t;

	typedef struct packed {
		logic       capture;
		op_t        op;
		logic [1:0] idx;
	} cmd_t;

	typedef struct packed {
		logic fallen;
		logic norm_zero;
		logic q_one;
	} status_t;

endpackage

// File: hw/rtl/fsc_in_if.sv
// Input sample channel
`timescale 1ns / 1ps
interface fsc_in_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] torso_up_cos;
	logic signed [15:0] accel_x;
	logic signed [15:0] accel_y;
	logic signed [15:0] accel_z;
	logic signed [15:0] gyro_x;
	logic signed [15:0] gyro_y;
	logic signed [15:0] gyro_z;
	logic               walk_standing;

	modport source (output valid, torso_up_cos, accel_x, accel_y, accel_z,
		gyro_x, gyro_y, gyro_z, walk_standing, input ready);
	modport sink (input valid, torso_up_cos, accel_x, accel_y, accel_z,
		gyro_x, gyro_y, gyro_z, walk_standing, output ready);
endinterface

// File: hw/rtl/fsc_out_if.sv
// Stability result channel
`timescale 1ns / 1ps
interface fsc_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] stability;

	modport source (output valid, stability, input ready);
	modport sink (input valid, stability, output ready);
endinterface

// File: hw/rtl/fsc_regs.sv
// APB configuration registers
`timescale 1ns / 1ps
module fsc_regs
	import fsc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output cfg_t        cfg
);
	cfg_t cfg_q;
	logic wr;

	assign pready = 1'b1;
	assign wr = psel && penable && pwrite;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.fallen_cos        <= 16'sd8192;
			cfg_q.gyro_mean         <= 17'd0;
			cfg_q.gyro_alpha        <= 16'd6554;
			cfg_q.gyro_falling      <= 17'd1280;
			cfg_q.acc_mag_alpha     <= 16'd6554;
			cfg_q.acc_mag_falling   <= 16'd1280;
			cfg_q.acc_angle_alpha   <= 16'd6554;
			cfg_q.acc_angle_falling <= 15'd8192;
		end else if (wr) begin
			case (paddr[4:2])
				REG_FALLEN_COS:        cfg_q.fallen_cos        <= pwdata[15:0];
				REG_GYRO_MEAN:         cfg_q.gyro_mean         <= pwdata[16:0];
				REG_GYRO_ALPHA:        cfg_q.gyro_alpha        <= pwdata[15:0];
				REG_GYRO_FALLING:      cfg_q.gyro_falling      <= pwdata[16:0];
				REG_ACC_MAG_ALPHA:     cfg_q.acc_mag_alpha     <= pwdata[15:0];
				REG_ACC_MAG_FALLING:   cfg_q.acc_mag_falling   <= pwdata[15:0];
				REG_ACC_ANGLE_ALPHA:   cfg_q.acc_angle_alpha   <= pwdata[15:0];
				REG_ACC_ANGLE_FALLING: cfg_q.acc_angle_falling <= pwdata[14:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			REG_FALLEN_COS:        prdata = {{16{cfg_q.fallen_cos[15]}}, cfg_q.fallen_cos};
			REG_GYRO_MEAN:         prdata = {15'd0, cfg_q.gyro_mean};
			REG_GYRO_ALPHA:        prdata = {16'd0, cfg_q.gyro_alpha};
			REG_GYRO_FALLING:      prdata = {15'd0, cfg_q.gyro_falling};
			REG_ACC_MAG_ALPHA:     prdata = {16'd0, cfg_q.acc_mag_alpha};
			REG_ACC_MAG_FALLING:   prdata = {16'd0, cfg_q.acc_mag_falling};
			REG_ACC_ANGLE_ALPHA:   prdata = {16'd0, cfg_q.acc_angle_alpha};
			REG_ACC_ANGLE_FALLING: prdata = {17'd0, cfg_q.acc_angle_falling};
			default:               prdata = 32'd0;
		endcase
	end
endmodule

// File: hw/rtl/fsc_ctrl.sv
// Sequencing state machine of the classifier
`timescale 1ns / 1ps
module fsc_ctrl
	import fsc_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	input  status_t status,
	output cmd_t    cmd
);
	typedef enum logic [16:0] {
		S_IDLE = 17'h00001, S_CHK  = 17'h00002, S_SQM  = 17'h00004, S_RTI  = 17'h00008,
		S_RT   = 17'h00010, S_NORM = 17'h00020, S_DVI  = 17'h00040, S_DV   = 17'h00080,
		S_QFIN = 17'h00100, S_HMUL = 17'h00200, S_HADD = 17'h00400, S_TMUL = 17'h00800,
		S_TILT = 17'h01000, S_SMA  = 17'h02000, S_SMB  = 17'h04000, S_SAVG = 17'h08000,
		S_OUT  = 17'h10000
	} state_t;

	state_t     state_q, state_d;
	logic [5:0] cnt_q, cnt_d;
	logic       phase_q, phase_d;
	logic       out_valid_q;
	logic       out_free;
	logic       out_load;

	assign out_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cnt_d = cnt_q;
		phase_d = phase_q;
		out_load = 1'b0;
		cmd.capture = 1'b0;
		cmd.op = OP_NOP;
		cmd.idx = cnt_q[1:0];
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d = S_CHK;
				end
			end
			S_CHK: begin
				cnt_d = 6'd0;
				state_d = status.fallen ? S_OUT : S_SQM;
			end
			S_SQM: begin
				cmd.op = OP_SQ;
				if (cnt_q == 6'd3) begin
					phase_d = 1'b0;
					state_d = S_RTI;
				end else begin
					cnt_d = cnt_q + 6'd1;
				end
			end
			S_RTI: begin
				cnt_d = 6'd0;
				if (phase_q && status.q_one) begin
					state_d = S_SMA;
				end else begin
					cmd.op = OP_ROOT_INIT;
					cmd.idx = {1'b0, phase_q};
					state_d = S_RT;
				end
			end
			S_RT: begin
				cmd.op = OP_ROOT_STEP;
				if (cnt_q == ROOT_LAST) begin
					cnt_d = 6'd0;
					state_d = phase_q ? S_HMUL : S_NORM;
				end else begin
					cnt_d = cnt_q + 6'd1;
				end
			end
			S_NORM: begin
				cmd.op = OP_NORM;
				state_d = S_DVI;
			end
			S_DVI: begin
				cnt_d = 6'd0;
				if (status.norm_zero) begin
					state_d = S_SMA;
				end else begin
					cmd.op = OP_DIV_INIT;
					state_d = S_DV;
				end
			end
			S_DV: begin
				cmd.op = OP_DIV_STEP;
				if (cnt_q == DIV_LAST) begin
					state_d = S_QFIN;
				end else begin
					cnt_d = cnt_q + 6'd1;
				end
			end
			S_QFIN: begin
				cmd.op = OP_QFIN;
				phase_d = 1'b1;
				state_d = S_RTI;
			end
			S_HMUL: begin
				cmd.op = OP_HMUL;
				state_d = S_HADD;
			end
			S_HADD: begin
				cmd.op = OP_HADD;
				if (cnt_q == 6'd2) begin
					state_d = S_TMUL;
				end else begin
					cnt_d = cnt_q + 6'd1;
					state_d = S_HMUL;
				end
			end
			S_TMUL: begin
				cmd.op = OP_TMUL;
				state_d = S_TILT;
			end
			S_TILT: begin
				cmd.op = OP_TILT;
				cnt_d = 6'd0;
				state_d = S_SMA;
			end
			S_SMA: begin
				cmd.op = OP_SMA;
				state_d = S_SMB;
			end
			S_SMB: begin
				cmd.op = OP_SMB;
				state_d = S_SAVG;
			end
			S_SAVG: begin
				cmd.op = OP_SAVG;
				if (cnt_q == 6'd2) begin
					state_d = S_OUT;
				end else begin
					cnt_d = cnt_q + 6'd1;
					state_d = S_SMA;
				end
			end
			S_OUT: begin
				if (out_free) begin
					cmd.op = OP_RESULT;
					out_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= 6'd0;
			phase_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q <= cnt_d;
			phase_q <= phase_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end
endmodule

// File: hw/rtl/fsc_datapath.sv
// Arithmetic datapath: squares, shared root, divider, polynomial, filters
`timescale 1ns / 1ps
module fsc_datapath
	import fsc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	input  cmd_t               cmd,
	input  logic signed [15:0] torso_up_cos,
	input  logic signed [15:0] accel_x,
	input  logic signed [15:0] accel_y,
	input  logic signed [15:0] accel_z,
	input  logic signed [15:0] gyro_x,
	input  logic signed [15:0] gyro_y,
	input  logic signed [15:0] gyro_z,
	input  logic               walk_standing,
	output status_t            status,
	output logic [1:0]         stability
);
	function automatic logic [15:0] abs16(input logic [15:0] v);
		abs16 = v[15] ? (~v + 16'd1) : v;
	endfunction

	logic signed [15:0] ax_q, ay_q, az_q;
	logic               fallen_q, standing_q;
	logic [16:0]        gterm_q;
	logic [31:0]        sq_q;
	logic [33:0]        rad_q;
	logic [18:0]        rem_q;
	logic [16:0]        root_q;
	logic [15:0]        norm_q;
	logic [31:0]        num_q;
	logic [15:0]        drem_q;
	logic [16:0]        q_q;
	logic signed [23:0] p_q;
	logic [14:0]        tilt_q;
	logic signed [42:0] prod_q;
	logic signed [42:0] acc_q;
	logic [16:0]        gyro_avg_q;
	logic [15:0]        norm_avg_q;
	logic [14:0]        tilt_avg_q;
	logic [1:0]         stab_q;

	logic [17:0]        l1;
	logic [16:0]        gterm_d;
	logic signed [24:0] mul_a;
	logic signed [17:0] mul_b;
	logic               mul_en;
	logic signed [15:0] axis;
	logic [15:0]        alpha;
	logic [16:0]        smx, smavg;
	logic [20:0]        rtrial, rsub;
	logic [16:0]        dtrial;
	logic               dge;
	logic signed [42:0] rnd;
	logic signed [23:0] p_next;
	logic [42:0]        tsum;
	logic [42:0]        ssum;
	logic               gflag, aflag, tflag;

	assign l1 = {2'b0, abs16(gyro_x)} + {2'b0, abs16(gyro_y)} + {2'b0, abs16(gyro_z)};
	assign gterm_d = (l1 >= {1'b0, cfg.gyro_mean}) ? 17'(l1 - {1'b0, cfg.gyro_mean})
		: 17'({1'b0, cfg.gyro_mean} - l1);

	always_comb begin
		case (cmd.idx)
			2'd0:    axis = ax_q;
			2'd1:    axis = ay_q;
			default: axis = az_q;
		endcase
		case (cmd.idx)
			2'd0: begin
				alpha = cfg.gyro_alpha;
				smx = gterm_q;
				smavg = gyro_avg_q;
			end
			2'd1: begin
				alpha = cfg.acc_mag_alpha;
				smx = {1'b0, norm_q};
				smavg = {1'b0, norm_avg_q};
			end
			default: begin
				alpha = cfg.acc_angle_alpha;
				smx = {2'b0, tilt_q};
				smavg = {2'b0, tilt_avg_q};
			end
		endcase
	end

	always_comb begin
		mul_en = 1'b1;
		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			OP_SQ: begin
				mul_a = {{9{axis[15]}}, axis};
				mul_b = {{2{axis[15]}}, axis};
			end
			OP_HMUL: begin
				mul_a = {p_q[23], p_q};
				mul_b = {1'b0, q_q};
			end
			OP_TMUL: begin
				mul_a = {p_q[23], p_q};
				mul_b = {1'b0, root_q};
			end
			OP_SMA: begin
				mul_a = {9'd0, alpha};
				mul_b = {1'b0, smx};
			end
			OP_SMB: begin
				mul_a = {8'd0, 17'(ONE_Q16 - {1'b0, alpha})};
				mul_b = {1'b0, smavg};
			end
			default: mul_en = 1'b0;
		endcase
	end

	assign rtrial = {rem_q, rad_q[33:32]};
	assign rsub = {2'b0, root_q, 2'b01};
	assign dtrial = {drem_q, num_q[31]};
	assign dge = dtrial >= {1'b0, norm_q};
	assign rnd = (prod_q + 43'sd32768) >>> 16;

	always_comb begin
		case (cmd.idx)
			2'd0:    p_next = 24'(rnd) + HORNER_C2;
			2'd1:    p_next = 24'(rnd) + HORNER_C1;
			default: p_next = 24'(rnd) + HORNER_C0;
		endcase
	end

	assign tsum = prod_q + 43'd4194304;
	assign ssum = acc_q + prod_q;

	assign gflag = gyro_avg_q >= cfg.gyro_falling;
	assign aflag = norm_avg_q <= cfg.acc_mag_falling;
	assign tflag = tilt_avg_q >= cfg.acc_angle_falling;

	assign status.fallen = fallen_q;
	assign status.norm_zero = (norm_q == 16'd0);
	assign status.q_one = q_q[16];
	assign stability = stab_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			ax_q <= accel_x;
			ay_q <= accel_y;
			az_q <= accel_z;
			standing_q <= walk_standing;
			fallen_q <= torso_up_cos < cfg.fallen_cos;
			gterm_q <= gterm_d;
			p_q <= HORNER_C3;
			tilt_q <= 15'd0;
		end
		if (mul_en) begin
			prod_q <= 43'(mul_a * mul_b);
		end
		case (cmd.op)
			OP_SQ: sq_q <= (cmd.idx == 2'd0) ? 32'd0 : sq_q + prod_q[31:0];
			OP_ROOT_INIT: begin
				rad_q <= cmd.idx[0] ? {1'b0, 17'(ONE_Q16 - q_q), 16'd0} : {2'b0, sq_q};
				rem_q <= 19'd0;
				root_q <= 17'd0;
			end
			OP_ROOT_STEP: begin
				rad_q <= {rad_q[31:0], 2'b00};
				if (rtrial >= rsub) begin
					rem_q <= 19'(rtrial - rsub);
					root_q <= {root_q[15:0], 1'b1};
				end else begin
					rem_q <= rtrial[18:0];
					root_q <= {root_q[15:0], 1'b0};
				end
			end
			OP_NORM: norm_q <= 16'(root_q + {16'd0, rem_q > {2'b0, root_q}});
			OP_DIV_INIT: begin
				num_q <= {abs16(az_q), 16'd0} + {17'd0, norm_q[15:1]};
				drem_q <= 16'd0;
			end
			OP_DIV_STEP: begin
				drem_q <= dge ? 16'(dtrial - {1'b0, norm_q}) : dtrial[15:0];
				num_q <= {num_q[30:0], dge};
			end
			OP_QFIN: q_q <= (num_q > {15'd0, ONE_Q16}) ? ONE_Q16 : num_q[16:0];
			OP_HADD: p_q <= (cmd.idx == 2'd2 && p_next < 0) ? 24'sd0 : p_next;
			OP_TILT: tilt_q <= tsum[37:23];
			OP_SMB: acc_q <= prod_q + 43'sd32768;
			OP_RESULT: begin
				if (fallen_q) begin
					stab_q <= ST_FALLEN;
				end else if ((gflag && aflag) || tflag) begin
					stab_q <= ST_FALLING;
				end else begin
					stab_q <= standing_q ? ST_STANDING : ST_STATIC;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gyro_avg_q <= 17'd0;
			norm_avg_q <= 16'd0;
			tilt_avg_q <= 15'd0;
		end else if (cmd.op == OP_SAVG) begin
			case (cmd.idx)
				2'd0:    gyro_avg_q <= ssum[32:16];
				2'd1:    norm_avg_q <= ssum[31:16];
				default: tilt_avg_q <= ssum[30:16];
			endcase
		end
	end
endmodule

// File: hw/rtl/fall_stability_classifier.sv
// Fall stability classifier top level
// One sample at a time; a sample the torso cosine marks fallen skips the arithmetic, and a
// new code waits while the last one sits in a full output register. The time is set by
// the bit-serial square root (for the norm, then for the tilt unless the norm is zero or
// the ratio is one) and the restoring divider for |az|/norm. A finished code waits in the
// output register as the next sample is taken. Registers are written over APB at 4*index.
`timescale 1ns / 1ps
`include "fall_stability_classifier_defines.svh"
module fall_stability_classifier
	import fsc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	fsc_in_if.sink      in_ch,
	fsc_out_if.source   out_ch,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	cfg_t    cfg;
	cmd_t    cmd;
	status_t status;

	fsc_regs u_regs (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
	);

	fsc_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready), .status(status), .cmd(cmd)
	);

	fsc_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cfg(cfg), .cmd(cmd),
		.torso_up_cos(in_ch.torso_up_cos), .accel_x(in_ch.accel_x),
		.accel_y(in_ch.accel_y), .accel_z(in_ch.accel_z), .gyro_x(in_ch.gyro_x),
		.gyro_y(in_ch.gyro_y), .gyro_z(in_ch.gyro_z), .walk_standing(in_ch.walk_standing),
		.status(status), .stability(out_ch.stability)
	);

	`FSC_ASSERT_NEXT(a_busy_after_transfer, in_ch.valid && in_ch.ready, !in_ch.ready, "ready after input transfer")
	`FSC_ASSERT_IMPL(a_result_from_busy, $rose(out_ch.valid), $past(!in_ch.ready), "result while idle")
endmodule
